/* src/cacc_pkg.sv */
`default_nettype none
package cacc_pkg;

   typedef enum logic [2:0] {
      CMD_LOAD = 3'd0,
      CMD_ADD  = 3'd1,
      CMD_SUB  = 3'd2,
      CMD_MUL  = 3'd3,
      CMD_DIV  = 3'd4
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_MUL4,
      ST_DEN1,
      ST_DEN2,
      ST_NUM1,
      ST_NUM2,
      ST_NUM3,
      ST_NUM4,
      ST_DIVR,
      ST_DIVI,
      ST_DONE
   } state_type;

   // multiplier operand selects
   typedef enum logic [2:0] {
      MSEL_ZR_WR,
      MSEL_ZI_WI,
      MSEL_ZR_WI,
      MSEL_ZI_WR,
      MSEL_ZR_ZR,
      MSEL_ZI_ZI
   } msel_type;

   // what to do with the product
   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_SET_A,
      ACC_SUB_A,
      ACC_SET_B,
      ACC_ADD_B,
      ACC_SUB_B,
      ACC_ADD_A,
      ACC_ADD_D
   } accop_type;

   typedef struct packed {
      logic      capture;
      logic      mul_en;
      msel_type  msel;
      accop_type accop;
      logic      div_start;
      logic      div_sel_imag;
      logic      fin_simple;
      logic      fin_mul;
      logic      fin_divr;
      logic      fin_divi;
      logic      fin_dz;
      logic      clr_den;
   } cmd_bus_type;

   typedef struct packed {
      logic    div_busy;
      logic    acc_zero;
      cmd_type cmd;
   } sts_bus_type;

endpackage
`default_nettype wire

/* src/cacc_if.sv */
`default_nettype none
interface cacc_req_if #(parameter int DATA_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic [2:0]                   cmd;
   logic signed [DATA_WIDTH-1:0] operand_real;
   logic signed [DATA_WIDTH-1:0] operand_imag;
   modport source (output valid, cmd, operand_real, operand_imag, input ready);
   modport sink   (input valid, cmd, operand_real, operand_imag, output ready);
endinterface

interface cacc_rsp_if #(parameter int DATA_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] result_real;
   logic signed [DATA_WIDTH-1:0] result_imag;
   logic                         saturated;
   logic                         divide_by_zero;
   modport source (output valid, result_real, result_imag, saturated, divide_by_zero,
                   input ready);
   modport sink   (input valid, result_real, result_imag, saturated, divide_by_zero,
                   output ready);
endinterface
`default_nettype wire

/* src/cacc_div.sv */
`default_nettype none
// restoring divider on magnitudes, one quotient bit per cycle
module cacc_div #(
   parameter int NW = 48,
   parameter int DW = 34,
   parameter int QW = 24
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               busy,
   output logic [QW-1:0]      quo,
   output logic               ovf
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] num_ff, num_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [QW-1:0] quo_ff, quo_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [DW+1:0] shifted;
   logic [DW+1:0] diff;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff, num_ff[NW-1]};
      diff    = shifted - {2'b00, den_ff};
      if (start) begin
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
         quo_in  = '0;
         ovf_in  = 1'b0;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         if (!diff[DW+1]) begin
            rem_in = diff[DW:0];
         end else begin
            rem_in = shifted[DW:0];
         end
         // any bit shifted out of the quotient register means it is too large
         if (quo_ff[QW-1]) begin
            ovf_in = 1'b1;
         end
         quo_in = {quo_ff[QW-2:0], ~diff[DW+1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;
   assign ovf  = ovf_ff;
endmodule
`default_nettype wire

/* src/cacc_dp.sv */
`default_nettype none
module cacc_dp #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cacc_pkg::cmd_bus_type        ctl,
   output cacc_pkg::sts_bus_type             sts,
   input  wire logic [2:0]                   in_cmd,
   input  wire logic signed [DATA_WIDTH-1:0] in_real,
   input  wire logic signed [DATA_WIDTH-1:0] in_imag,
   output logic signed [DATA_WIDTH-1:0]      res_real,
   output logic signed [DATA_WIDTH-1:0]      res_imag,
   output logic                              res_sat,
   output logic                              res_dz
);
   import cacc_pkg::*;

   localparam int DW = DATA_WIDTH;
   localparam int PW = 2 * DW;
   localparam int SW = PW + 2;
   localparam int NW = PW + 1 + FRAC_BITS;
   localparam int QW = DW + 1;
   localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (DW - 1)) - 1);
   localparam logic signed [SW-1:0] SMIN = -SW'(64'sd1 <<< (DW - 1));

   logic signed [DW-1:0] zr_ff, zi_ff, zr_in, zi_in;
   logic signed [DW-1:0] wr_ff, wi_ff;
   logic [2:0]           cmd_ff;
   logic signed [SW-1:0] sa_ff, sb_ff, sa_in, sb_in;
   logic [PW:0]          den_ff, den_in;
   logic signed [PW-1:0] prod_ff;
   logic signed [DW-1:0] ma, mb;
   logic signed [DW-1:0] rr_ff, ri_ff, rr_in, ri_in;
   logic                 sat_ff, sat_in, dz_ff, dz_in;
   logic                 dbusy, dovf;
   logic [QW-1:0]        dquo;
   logic signed [SW-1:0] dnum_s;
   logic                 dneg_ff, dneg_in;
   logic [NW-1:0]        dnum;
   logic signed [SW-1:0] t;
   logic                 tsat;
   logic signed [DW-1:0] tval;

   function automatic logic signed [DW-1:0] clampv(input logic signed [SW-1:0] v,
                                                   output logic s);
      s = 1'b0;
      if (v > SMAX) begin
         s = 1'b1;
         return DW'(SMAX);
      end
      if (v < SMIN) begin
         s = 1'b1;
         return DW'(SMIN);
      end
      return DW'(v);
   endfunction

   always_comb begin
      case (ctl.msel)
         MSEL_ZR_WR: begin ma = zr_ff; mb = wr_ff; end
         MSEL_ZI_WI: begin ma = zi_ff; mb = wi_ff; end
         MSEL_ZR_WI: begin ma = zr_ff; mb = wi_ff; end
         MSEL_ZI_WR: begin ma = zi_ff; mb = wr_ff; end
         MSEL_ZR_ZR: begin ma = zr_ff; mb = zr_ff; end
         default:    begin ma = zi_ff; mb = zi_ff; end
      endcase
   end

   // divider input: signed numerator to magnitude, scaled by the fraction bits
   assign dnum_s = ctl.div_sel_imag ? sb_ff : sa_ff;
   always_comb begin
      dneg_in = dneg_ff;
      dnum    = NW'(dnum_s[SW-1] ? -dnum_s : dnum_s) << FRAC_BITS;
      if (ctl.div_start) begin
         dneg_in = dnum_s[SW-1];
      end
   end

   cacc_div #(.NW(NW), .DW(PW + 1), .QW(QW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (ctl.div_start),
      .num   (dnum),
      .den   (den_ff),
      .busy  (dbusy),
      .quo   (dquo),
      .ovf   (dovf)
   );

   always_comb begin
      sa_in  = sa_ff;
      sb_in  = sb_ff;
      den_in = den_ff;
      if (ctl.clr_den) begin
         den_in = '0;
      end
      case (ctl.accop)
         ACC_SET_A: sa_in = SW'(prod_ff);
         ACC_SUB_A: sa_in = sa_ff - SW'(prod_ff);
         ACC_ADD_A: sa_in = sa_ff + SW'(prod_ff);
         ACC_SET_B: sb_in = SW'(prod_ff);
         ACC_ADD_B: sb_in = sb_ff + SW'(prod_ff);
         ACC_SUB_B: sb_in = sb_ff - SW'(prod_ff);
         ACC_ADD_D: den_in = den_ff + (PW + 1)'(unsigned'(prod_ff));
         default: ;
      endcase
   end

   always_comb begin
      zr_in  = zr_ff;
      zi_in  = zi_ff;
      rr_in  = rr_ff;
      ri_in  = ri_ff;
      sat_in = sat_ff;
      dz_in  = dz_ff;
      t      = '0;
      tsat   = 1'b0;
      tval   = '0;
      if (ctl.fin_simple) begin
         dz_in  = 1'b0;
         sat_in = 1'b0;
         rr_in  = zr_ff;
         ri_in  = zi_ff;
         if (cmd_ff == CMD_LOAD) begin
            rr_in = wr_ff;
            ri_in = wi_ff;
         end else if (cmd_ff == CMD_ADD || cmd_ff == CMD_SUB) begin
            t = (cmd_ff == CMD_ADD) ? SW'(zr_ff) + SW'(wr_ff) : SW'(zr_ff) - SW'(wr_ff);
            rr_in = clampv(t, tsat);
            sat_in = tsat;
            t = (cmd_ff == CMD_ADD) ? SW'(zi_ff) + SW'(wi_ff) : SW'(zi_ff) - SW'(wi_ff);
            ri_in = clampv(t, tsat);
            sat_in = sat_in | tsat;
         end
         zr_in = rr_in;
         zi_in = ri_in;
      end
      if (ctl.fin_mul) begin
         dz_in  = 1'b0;
         rr_in  = clampv(sa_ff >>> FRAC_BITS, tsat);
         sat_in = tsat;
         ri_in  = clampv(sb_ff >>> FRAC_BITS, tsat);
         sat_in = sat_in | tsat;
         zr_in  = rr_in;
         zi_in  = ri_in;
      end
      if (ctl.fin_dz) begin
         dz_in  = 1'b1;
         sat_in = 1'b0;
         rr_in  = zr_ff;
         ri_in  = zi_ff;
      end
      if (ctl.fin_divr || ctl.fin_divi) begin
         t = dovf ? SMAX + SW'(2) : SW'(dquo);
         if (dneg_ff) begin
            t = -t;
         end
         tval = clampv(t, tsat);
         if (ctl.fin_divr) begin
            dz_in  = 1'b0;
            rr_in  = tval;
            sat_in = tsat;
         end else begin
            ri_in  = tval;
            sat_in = sat_ff | tsat;
            zr_in  = rr_ff;
            zi_in  = tval;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zr_ff <= '0;
         zi_ff <= '0;
      end else begin
         zr_ff <= zr_in;
         zi_ff <= zi_in;
      end
      if (ctl.capture) begin
         wr_ff  <= in_real;
         wi_ff  <= in_imag;
         cmd_ff <= in_cmd;
      end
      if (ctl.mul_en) begin
         prod_ff <= ma * mb;
      end
      sa_ff   <= sa_in;
      sb_ff   <= sb_in;
      den_ff  <= den_in;
      dneg_ff <= dneg_in;
      rr_ff   <= rr_in;
      ri_ff   <= ri_in;
      sat_ff  <= sat_in;
      dz_ff   <= dz_in;
   end

   assign sts.div_busy = dbusy;
   assign sts.acc_zero = (zr_ff == '0) && (zi_ff == '0);
   assign sts.cmd      = cmd_type'(cmd_ff);
   assign res_real = rr_ff;
   assign res_imag = ri_ff;
   assign res_sat  = sat_ff;
   assign res_dz   = dz_ff;

   a_dz_no_sat: assert property (@(posedge clock) disable iff (reset)
      $past(ctl.fin_dz) |-> (dz_ff && !sat_ff)) else $error("dz with sat");
   a_dz_keeps: assert property (@(posedge clock) disable iff (reset)
      ctl.fin_dz |=> $stable(zr_ff) && $stable(zi_ff)) else $error("dz changed acc");
   a_div_idle_start: assert property (@(posedge clock) disable iff (reset)
      ctl.div_start |-> !dbusy) else $error("divider restarted");
endmodule
`default_nettype wire

/* src/cacc_ctrl.sv */
`default_nettype none
module cacc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire cacc_pkg::sts_bus_type sts,
   output cacc_pkg::cmd_bus_type      ctl
);
   import cacc_pkg::*;

   state_type state_ff, state_in;
   logic      rv_ff, rv_in;
   logic      dwait_ff, dwait_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         dwait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         dwait_ff <= dwait_in;
      end
   end

   // a new word may enter once the previous result has been taken
   assign req_ready = (state_ff == ST_IDLE) && (!rv_ff || rsp_ready);
   assign rsp_valid = rv_ff;

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      ctl.msel = MSEL_ZR_WR;
      ctl.accop = ACC_NONE;
      rv_in    = rv_ff && !rsp_ready;
      dwait_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               ctl.capture = 1'b1;
               state_in    = ST_MUL1;
            end
         end
         ST_MUL1: begin
            unique case (sts.cmd)
               CMD_MUL: begin
                  ctl.mul_en = 1'b1;
                  ctl.msel   = MSEL_ZR_WR;
                  state_in   = ST_MUL2;
               end
               CMD_DIV: begin
                  if (sts.acc_zero) begin
                     ctl.fin_dz = 1'b1;
                     state_in   = ST_DONE;
                  end else begin
                     ctl.mul_en  = 1'b1;
                     ctl.msel    = MSEL_ZR_ZR;
                     ctl.clr_den = 1'b1;
                     state_in    = ST_DEN1;
                  end
               end
               default: begin
                  ctl.fin_simple = 1'b1;
                  state_in       = ST_DONE;
               end
            endcase
         end
         ST_MUL2: begin
            ctl.accop = ACC_SET_A; ctl.mul_en = 1'b1; ctl.msel = MSEL_ZI_WI;
            state_in  = ST_MUL3;
         end
         ST_MUL3: begin
            ctl.accop = ACC_SUB_A; ctl.mul_en = 1'b1; ctl.msel = MSEL_ZR_WI;
            state_in  = ST_MUL4;
         end
         ST_MUL4: begin
            ctl.accop = ACC_SET_B; ctl.mul_en = 1'b1; ctl.msel = MSEL_ZI_WR;
            state_in  = ST_NUM4;
         end
         ST_DEN1: begin
            ctl.accop = ACC_ADD_D; ctl.mul_en = 1'b1; ctl.msel = MSEL_ZI_ZI;
            state_in  = ST_DEN2;
         end
         ST_DEN2: begin
            ctl.accop = ACC_ADD_D; ctl.mul_en = 1'b1; ctl.msel = MSEL_ZR_WR;
            state_in  = ST_NUM1;
         end
         ST_NUM1: begin
            ctl.accop = ACC_SET_A; ctl.mul_en = 1'b1; ctl.msel = MSEL_ZI_WI;
            state_in  = ST_NUM2;
         end
         ST_NUM2: begin
            ctl.accop = ACC_ADD_A; ctl.mul_en = 1'b1; ctl.msel = MSEL_ZR_WI;
            state_in  = ST_NUM3;
         end
         ST_NUM3: begin
            ctl.accop = ACC_SET_B; ctl.mul_en = 1'b1; ctl.msel = MSEL_ZI_WR;
            state_in  = ST_NUM4;
         end
         ST_NUM4: begin
            // last product: add for multiply, subtract for divide
            if (sts.cmd == CMD_MUL) begin
               ctl.accop = ACC_ADD_B;
               state_in  = ST_DONE;
            end else begin
               ctl.accop = ACC_SUB_B;
               state_in  = ST_DIVR;
               dwait_in  = 1'b1;
            end
         end
         ST_DIVR: begin
            if (dwait_ff) begin
               ctl.div_start = 1'b1;
            end else if (!sts.div_busy) begin
               ctl.fin_divr     = 1'b1;
               ctl.div_start    = 1'b1;
               ctl.div_sel_imag = 1'b1;
               state_in         = ST_DIVI;
            end
         end
         ST_DIVI: begin
            if (!sts.div_busy && !dwait_ff) begin
               ctl.fin_divi = 1'b1;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            // multiply results are registered here before the response is raised on the next pass
            if (sts.cmd == CMD_MUL && !dwait_ff) begin
               ctl.fin_mul = 1'b1;
               dwait_in    = 1'b1;
            end else begin
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_one_fin: assert property (@(posedge clock) disable iff (reset)
      $countones({ctl.fin_simple, ctl.fin_mul, ctl.fin_dz, ctl.fin_divr, ctl.fin_divi}) <= 1)
      else $error("two finishes at once");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rv_ff) |-> $past(state_ff) == ST_DONE) else $error("result out of order");
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready) else $error("accept while busy");
endmodule
`default_nettype wire

/* src/complex_accumulator_alu_top.sv */
`default_nettype none
// Complex accumulator: keeps z in signed fixed point and applies load, add,
// subtract, multiply or divide (z = w / z) for each request word, returning the new z
// with saturation and divide-by-zero flags. Divide runs the bit-serial divider once for
// each part. One multiplier is shared by all products. One word is worked on at a time.
module complex_accumulator_alu_top #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 8
) (
   input wire logic  clock,
   input wire logic  reset,
   cacc_req_if.sink  req,
   cacc_rsp_if.source rsp
);
   import cacc_pkg::*;

   cmd_bus_type ctl;
   sts_bus_type sts;

   cacc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   cacc_dp #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .sts      (sts),
      .in_cmd   (req.cmd),
      .in_real  (req.operand_real),
      .in_imag  (req.operand_imag),
      .res_real (rsp.result_real),
      .res_imag (rsp.result_imag),
      .res_sat  (rsp.saturated),
      .res_dz   (rsp.divide_by_zero)
   );
endmodule
`default_nettype wire

/* test/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cacc_pkg::*;

   localparam int DW = 16;
   localparam int FB = 8;
   localparam longint POS_MAX = (64'sd1 <<< (DW - 1)) - 1;
   localparam longint NEG_MIN = -(64'sd1 <<< (DW - 1));

   typedef struct {
      logic signed [DW-1:0] re;
      logic signed [DW-1:0] im;
      logic                 sat;
      logic                 dz;
   } zword_t;

   // scoreboard: tracks accumulator and queue of expected z words
   class acc_scoreboard;
      longint zr, zi;
      zword_t pending[$];
      int errors;

      function new();
         zr = 0;
         zi = 0;
         errors = 0;
      endfunction

      function longint clip(longint v, ref logic sat);
         if (v > POS_MAX) begin
            sat = 1;
            return POS_MAX;
         end
         if (v < NEG_MIN) begin
            sat = 1;
            return NEG_MIN;
         end
         return v;
      endfunction

      // floor shift of exact product sum
      function longint shrink(longint v, ref logic sat);
         return clip(v >>> FB, sat);
      endfunction

      // quotient truncated toward zero
      function longint qdiv(longint num, longint den, ref logic sat);
         longint mag, q;
         logic neg;
         neg = num < 0;
         mag = neg ? -num : num;
         q = mag / den;
         if (q > (POS_MAX + 1)) begin
            sat = 1;
            return neg ? NEG_MIN : POS_MAX;
         end
         q = (mag << FB) / den;
         return clip(neg ? -q : q, sat);
      endfunction

      function void note_word(logic [2:0] cmd, logic signed [DW-1:0] wr_in,
                              logic signed [DW-1:0] wi_in);
         zword_t e;
         longint wr, wi, nr, ni, den;
         wr = wr_in;
         wi = wi_in;
         nr = zr;
         ni = zi;
         e.sat = 0;
         e.dz = 0;
         case (cmd)
            CMD_LOAD: begin
               nr = wr;
               ni = wi;
            end
            CMD_ADD: begin
               nr = clip(zr + wr, e.sat);
               ni = clip(zi + wi, e.sat);
            end
            CMD_SUB: begin
               nr = clip(zr - wr, e.sat);
               ni = clip(zi - wi, e.sat);
            end
            CMD_MUL: begin
               nr = shrink(zr * wr - zi * wi, e.sat);
               ni = shrink(zr * wi + zi * wr, e.sat);
            end
            CMD_DIV: begin
               if (zr == 0 && zi == 0) e.dz = 1;
               else begin
                  den = zr * zr + zi * zi;
                  nr = qdiv(wr * zr + wi * zi, den, e.sat);
                  ni = qdiv(wi * zr - wr * zi, den, e.sat);
               end
            end
            default: ;
         endcase
         zr = nr;
         zi = ni;
         e.re = nr[DW-1:0];
         e.im = ni[DW-1:0];
         pending.push_back(e);
      endfunction

      function void check_word(zword_t got);
         zword_t e;
         if (pending.size() == 0) begin
            report("unexpected result word");
            return;
         end
         e = pending.pop_front();
         if (got.re !== e.re) report($sformatf("real got %0d exp %0d", got.re, e.re));
         if (got.im !== e.im) report($sformatf("imag got %0d exp %0d", got.im, e.im));
         if (got.sat !== e.sat) report($sformatf("saturated got %b exp %b", got.sat, e.sat));
         if (got.dz !== e.dz) report($sformatf("divide_by_zero got %b exp %b", got.dz, e.dz));
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= 50) $display("[%0t] error: %s", $realtime, msg);
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   bit   calm = 0;
   acc_scoreboard sb = new();

   cacc_req_if #(.DATA_WIDTH(DW)) req();
   cacc_rsp_if #(.DATA_WIDTH(DW)) rsp();

   complex_accumulator_alu_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   always #1 clock = ~clock;

   initial begin
      req.valid = 0;
      req.cmd = '0;
      req.operand_real = '0;
      req.operand_imag = '0;
      rsp.ready = 0;
   end

   // sink side: random stall bursts
   initial begin
      int gap;
      @(posedge clock);
      forever begin
         rsp.ready <= 1;
         gap = calm ? 0 : $urandom_range(0, 12);
         repeat ($urandom_range(1, 10)) @(posedge clock);
         if (gap > 4) begin
            rsp.ready <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      zword_t got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.re = rsp.result_real;
         got.im = rsp.result_imag;
         got.sat = rsp.saturated;
         got.dz = rsp.divide_by_zero;
         sb.check_word(got);
      end
   end

   task automatic send_word(logic [2:0] cmd, logic signed [DW-1:0] wr,
                            logic signed [DW-1:0] wi);
      req.valid <= 1;
      req.cmd <= cmd;
      req.operand_real <= wr;
      req.operand_imag <= wi;
      do @(posedge clock); while (!req.ready);
      sb.note_word(cmd, wr, wi);
      if (!calm && $urandom_range(0, 3) == 0) begin
         req.valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   function automatic logic signed [DW-1:0] rand_part();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return $urandom_range(0, 1) ? 16'sh0000 : 16'sh0100;
         3: return DW'($signed($urandom_range(0, 1023)) - 512);
         default: return DW'($urandom);
      endcase
   endfunction

   initial begin
      logic [2:0] c;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed
      send_word(CMD_DIV, 16'sh0100, 16'sh0100);      // zero divisor after reset
      send_word(CMD_LOAD, 16'sh7fff, 16'sh8000);
      send_word(CMD_ADD, 16'sh7fff, 16'sh8000);      // saturate both ways
      send_word(CMD_SUB, 16'sh8000, 16'sh7fff);
      send_word(CMD_MUL, 16'sh7fff, 16'sh7fff);
      send_word(CMD_LOAD, 16'sh0100, 16'sh0000);
      send_word(CMD_MUL, 16'sh0180, 16'shff40);
      send_word(CMD_DIV, 16'sh0300, 16'sh0200);
      send_word(CMD_LOAD, 16'sh0001, 16'sh0000);
      send_word(CMD_DIV, 16'sh7fff, 16'sh8000);      // huge quotient
      send_word(CMD_LOAD, 16'sh8000, 16'sh8000);
      send_word(CMD_MUL, 16'sh8000, 16'sh8000);
      send_word(CMD_LOAD, 16'shff00, 16'sh0080);
      send_word(CMD_DIV, 16'shfe01, 16'sh0003);
      send_word(3'd5, 16'sh1234, 16'sh4321);
      send_word(3'd6, 16'sh0000, 16'sh0000);
      send_word(3'd7, 16'shffff, 16'shffff);
      send_word(CMD_LOAD, 16'sh0000, 16'sh0000);
      send_word(CMD_DIV, 16'sh0000, 16'sh0000);
      // hold off until drained
      req.valid <= 0;
      wait (sb.pending.size() == 0);
      @(posedge clock);
      for (int i = 0; i < 1400; i++) begin
         if (i == 1200) calm = 1;
         c = $urandom_range(0, 19) == 0 ? 3'($urandom_range(5, 7))
                                        : 3'($urandom_range(0, 4));
         // keep magnitudes useful: reload often
         if ($urandom_range(0, 5) == 0) c = CMD_LOAD;
         send_word(c, rand_part(), rand_part());
      end
      req.valid <= 0;
      wait (sb.pending.size() == 0);
      repeat (200) @(posedge clock);
      if (sb.errors == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
